/* hw/rtl/olir_pkg.sv */
`timescale 1ns / 1ps
// Shared types and codes for the ordered list unit.
// Used by olir_ctrl, olir_dpath and the top level; depends on nothing else.
package olir_pkg;

  // Fixed field widths of the item and result words
  localparam int ACTION_W    = 3;
  localparam int INDEX_W     = 8;
  localparam int VALUE_W     = 32;
  localparam int STATUS_W    = 2;
  localparam int DATA_OUT_W  = 32;
  localparam int FOUND_W     = 6;
  localparam int COUNT_OUT_W = 7;

  typedef logic [ACTION_W-1:0] action_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam action_t ACT_INSERT     = 3'd0;
  localparam action_t ACT_APPEND     = 3'd1;
  localparam action_t ACT_READ       = 3'd2;
  localparam action_t ACT_REMOVE     = 3'd3;
  localparam action_t ACT_REMOVE_VAL = 3'd4;
  localparam action_t ACT_OVERWRITE  = 3'd5;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_RANGE    = 2'd1;
  localparam status_t ST_FULL     = 2'd2;
  localparam status_t ST_NOTFOUND = 2'd3;

  // Read address source for the entry RAM
  typedef enum logic [2:0] {
    RD_NONE,
    RD_POS,
    RD_CNT_M1,
    RD_PTR_M2,
    RD_PTR_P1,
    RD_PTR_P2,
    RD_ZERO
  } rd_sel_t;

  // Write kind: move an entry to ptr, or put the item value at pos
  typedef enum logic [1:0] {
    WR_NONE,
    WR_SHIFT,
    WR_PUT
  } wr_sel_t;

  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_COUNT,
    PTR_POS,
    PTR_ZERO,
    PTR_INC,
    PTR_DEC
  } ptr_op_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_t;

  typedef struct packed {
    logic    load;
    logic    clr_result;
    logic    st_set;
    status_t st_code;
    rd_sel_t rd_sel;
    wr_sel_t wr_sel;
    ptr_op_t ptr_op;
    cnt_op_t cnt_op;
    logic    take_data;
    logic    take_where;
    logic    out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    action_t act;
    logic    pos_gt_count;
    logic    pos_eq_count;
    logic    pos_lt_count;
    logic    full;
    logic    count_zero;
    logic    ins_last;
    logic    more_p1;
    logic    more_p2;
    logic    match;
  } dp_flags_t;

endpackage

/* hw/rtl/olir_ram.sv */
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Self-contained; no package needed.
module olir_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hw/rtl/olir_dpath.sv */
`timescale 1ns / 1ps
// Datapath of the ordered list unit: entry RAM, count, pointer and result word.
// Depends on olir_pkg and olir_ram; driven by commands from olir_ctrl.
module olir_dpath #(
  parameter int CAPACITY     = 64,
  parameter int ELEMENT_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  olir_pkg::ctrl_cmd_t               cmd,
  output olir_pkg::dp_flags_t               flags,
  input  logic [olir_pkg::ACTION_W-1:0]     action,
  input  logic [olir_pkg::INDEX_W-1:0]      index,
  input  logic [olir_pkg::VALUE_W-1:0]      value,
  output logic [olir_pkg::STATUS_W-1:0]     status,
  output logic [olir_pkg::DATA_OUT_W-1:0]   data_out,
  output logic [olir_pkg::FOUND_W-1:0]      found_position,
  output logic [olir_pkg::COUNT_OUT_W-1:0]  entry_count
);
  import olir_pkg::*;

  localparam int AW  = $clog2(CAPACITY);
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int PW  = (CW > INDEX_W) ? CW : INDEX_W;
  localparam int CW1 = CW + 1;
  localparam int PW1 = PW + 1;

  action_t                 act;
  logic [PW-1:0]           pos;
  logic [ELEMENT_BITS-1:0] val;
  logic [CW-1:0]           count;
  logic [CW-1:0]           count_next;
  logic [CW-1:0]           ptr;
  logic [CW-1:0]           ptr_next;
  logic [ELEMENT_BITS-1:0] held;
  logic [AW-1:0]           where_pos;
  status_t                 res_status;

  logic                    ram_wr_en;
  logic [AW-1:0]           ram_wr_addr;
  logic [ELEMENT_BITS-1:0] ram_wr_data;
  logic                    ram_rd_en;
  logic [AW-1:0]           ram_rd_addr;
  logic [ELEMENT_BITS-1:0] ram_rd_data;

  logic [PW-1:0]  count_ext;
  logic [CW1-1:0] ptr_p1;
  logic [CW1-1:0] ptr_p2;
  logic [CW1-1:0] count_w;

  olir_ram #(
    .WIDTH (ELEMENT_BITS),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign count_ext = PW'(count);
  assign ptr_p1    = CW1'(ptr) + CW1'(1);
  assign ptr_p2    = CW1'(ptr) + CW1'(2);
  assign count_w   = CW1'(count);

  always_comb begin
    flags.act          = act;
    flags.pos_gt_count = pos > count_ext;
    flags.pos_eq_count = pos == count_ext;
    flags.pos_lt_count = pos < count_ext;
    flags.full         = count == CW'(CAPACITY);
    flags.count_zero   = count == '0;
    flags.ins_last     = PW1'(ptr) == (PW1'(pos) + PW1'(1));
    flags.more_p1      = ptr_p1 < count_w;
    flags.more_p2      = ptr_p2 < count_w;
    flags.match        = ram_rd_data == val;
  end

  always_comb begin
    ram_rd_en   = cmd.rd_sel != RD_NONE;
    ram_rd_addr = '0;
    unique case (cmd.rd_sel)
      RD_POS:    ram_rd_addr = AW'(pos);
      RD_CNT_M1: ram_rd_addr = AW'(count - CW'(1));
      RD_PTR_M2: ram_rd_addr = AW'(ptr - CW'(2));
      RD_PTR_P1: ram_rd_addr = AW'(ptr_p1);
      RD_PTR_P2: ram_rd_addr = AW'(ptr_p2);
      default:   ram_rd_addr = '0;
    endcase
  end

  always_comb begin
    ram_wr_en   = cmd.wr_sel != WR_NONE;
    ram_wr_addr = AW'(ptr);
    ram_wr_data = ram_rd_data;
    if (cmd.wr_sel == WR_PUT) begin
      ram_wr_addr = AW'(pos);
      ram_wr_data = val;
    end
  end

  always_comb begin
    ptr_next = ptr;
    unique case (cmd.ptr_op)
      PTR_COUNT: ptr_next = count;
      PTR_POS:   ptr_next = CW'(pos);
      PTR_ZERO:  ptr_next = '0;
      PTR_INC:   ptr_next = ptr + CW'(1);
      PTR_DEC:   ptr_next = ptr - CW'(1);
      default:   ptr_next = ptr;
    endcase
  end

  always_comb begin
    count_next = count;
    unique case (cmd.cnt_op)
      CNT_INC: count_next = count + CW'(1);
      CNT_DEC: count_next = count - CW'(1);
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    ptr <= ptr_next;
    if (cmd.load) begin
      act <= action;
      // append is an insert at the current end
      pos <= (action == ACT_APPEND) ? count_ext : PW'(index);
      val <= ELEMENT_BITS'(value);
    end
    if (cmd.clr_result) begin
      held       <= '0;
      where_pos  <= '0;
      res_status <= ST_OK;
    end
    if (cmd.st_set) begin
      res_status <= cmd.st_code;
    end
    if (cmd.take_data) begin
      held <= ram_rd_data;
    end
    if (cmd.take_where) begin
      where_pos <= AW'(ptr);
    end
    if (cmd.out_load) begin
      status         <= res_status;
      data_out       <= DATA_OUT_W'(held);
      found_position <= FOUND_W'(where_pos);
      entry_count    <= COUNT_OUT_W'(count);
    end
  end

endmodule

/* hw/rtl/olir_ctrl.sv */
`timescale 1ns / 1ps
// Controller of the ordered list unit: sequences each operation over the RAM.
// Depends on olir_pkg; issues commands to olir_dpath and reads its flags.
module olir_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  olir_pkg::dp_flags_t flags,
  output olir_pkg::ctrl_cmd_t cmd
);
  import olir_pkg::*;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DECODE    = 4'd1;
  localparam logic [3:0] S_INS_SHIFT = 4'd2;
  localparam logic [3:0] S_INS_PUT   = 4'd3;
  localparam logic [3:0] S_FETCH     = 4'd4;
  localparam logic [3:0] S_REM_SHIFT = 4'd5;
  localparam logic [3:0] S_SCAN      = 4'd6;
  localparam logic [3:0] S_DONE      = 4'd7;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       out_valid_next;
  logic       out_free;

  assign in_stall = state != S_IDLE;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.st_code    = ST_OK;
    cmd.rd_sel     = RD_NONE;
    cmd.wr_sel     = WR_NONE;
    cmd.ptr_op     = PTR_HOLD;
    cmd.cnt_op     = CNT_HOLD;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.clr_result = 1'b1;
        state_next     = S_DONE;
        unique case (flags.act)
          ACT_INSERT, ACT_APPEND: begin
            if (flags.act == ACT_INSERT && flags.pos_gt_count) begin
              cmd.st_set  = 1'b1;
              cmd.st_code = ST_RANGE;
            end else if (flags.full) begin
              cmd.st_set  = 1'b1;
              cmd.st_code = ST_FULL;
            end else if (flags.pos_eq_count) begin
              state_next = S_INS_PUT;
            end else begin
              // open the gap from the top down
              cmd.rd_sel = RD_CNT_M1;
              cmd.ptr_op = PTR_COUNT;
              state_next = S_INS_SHIFT;
            end
          end
          ACT_READ, ACT_REMOVE, ACT_OVERWRITE: begin
            if (!flags.pos_lt_count) begin
              cmd.st_set  = 1'b1;
              cmd.st_code = ST_RANGE;
            end else begin
              cmd.rd_sel = RD_POS;
              cmd.ptr_op = PTR_POS;
              state_next = S_FETCH;
            end
          end
          ACT_REMOVE_VAL: begin
            if (flags.count_zero) begin
              cmd.st_set  = 1'b1;
              cmd.st_code = ST_NOTFOUND;
            end else begin
              cmd.rd_sel = RD_ZERO;
              cmd.ptr_op = PTR_ZERO;
              state_next = S_SCAN;
            end
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end
      S_INS_SHIFT: begin
        cmd.wr_sel = WR_SHIFT;
        cmd.ptr_op = PTR_DEC;
        if (flags.ins_last) begin
          state_next = S_INS_PUT;
        end else begin
          cmd.rd_sel = RD_PTR_M2;
        end
      end
      S_INS_PUT: begin
        cmd.wr_sel = WR_PUT;
        cmd.cnt_op = CNT_INC;
        state_next = S_DONE;
      end
      S_FETCH: begin
        cmd.take_data = 1'b1;
        state_next    = S_DONE;
        if (flags.act == ACT_OVERWRITE) begin
          cmd.wr_sel = WR_PUT;
        end else if (flags.act == ACT_REMOVE) begin
          if (flags.more_p1) begin
            cmd.rd_sel = RD_PTR_P1;
            state_next = S_REM_SHIFT;
          end else begin
            cmd.cnt_op = CNT_DEC;
          end
        end
      end
      S_REM_SHIFT: begin
        // close the gap from the bottom up
        cmd.wr_sel = WR_SHIFT;
        cmd.ptr_op = PTR_INC;
        if (flags.more_p2) begin
          cmd.rd_sel = RD_PTR_P2;
        end else begin
          cmd.cnt_op = CNT_DEC;
          state_next = S_DONE;
        end
      end
      S_SCAN: begin
        if (flags.match) begin
          cmd.take_data  = 1'b1;
          cmd.take_where = 1'b1;
          if (flags.more_p1) begin
            cmd.rd_sel = RD_PTR_P1;
            state_next = S_REM_SHIFT;
          end else begin
            cmd.cnt_op = CNT_DEC;
            state_next = S_DONE;
          end
        end else if (flags.more_p1) begin
          cmd.rd_sel = RD_PTR_P1;
          cmd.ptr_op = PTR_INC;
        end else begin
          cmd.st_set  = 1'b1;
          cmd.st_code = ST_NOTFOUND;
          state_next  = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the output register can take the word
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid && out_stall;
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

/* hw/rtl/ordered_list_insert_remove_unit.sv */
`timescale 1ns / 1ps
// Top level of the ordered list unit: fixed-capacity list with insert/remove.
// Depends on olir_pkg, olir_ctrl, olir_dpath and olir_ram.
//
//   channel | handshake           | word
//   --------+---------------------+-------------------------------------------
//   in      | in_valid / in_stall | action, index, value
//   out     | out_valid/out_stall | status, data_out, found_position,
//           |                     | entry_count
//
// Errors and unused codes go from decode straight to the result state; insert
// and removes also step through the entries one at a time, since every entry
// moved or searched uses the single write port and registered read port of
// the entry RAM.
// Reset clears the count and the handshake state; no clearing pass is needed.
// A new item is taken while the last result still waits in the output register.
module ordered_list_insert_remove_unit #(
  parameter int CAPACITY     = 64,
  parameter int ELEMENT_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [olir_pkg::ACTION_W-1:0]     action,
  input  logic [olir_pkg::INDEX_W-1:0]      index,
  input  logic [olir_pkg::VALUE_W-1:0]      value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [olir_pkg::STATUS_W-1:0]     status,
  output logic [olir_pkg::DATA_OUT_W-1:0]   data_out,
  output logic [olir_pkg::FOUND_W-1:0]      found_position,
  output logic [olir_pkg::COUNT_OUT_W-1:0]  entry_count
);
  import olir_pkg::*;

  ctrl_cmd_t cmd;
  dp_flags_t flags;

  olir_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .flags     (flags),
    .cmd       (cmd)
  );

  olir_dpath #(
    .CAPACITY     (CAPACITY),
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .flags          (flags),
    .action         (action),
    .index          (index),
    .value          (value),
    .status         (status),
    .data_out       (data_out),
    .found_position (found_position),
    .entry_count    (entry_count)
  );

endmodule
